@@ rtl/mtg_pkg.sv @@
// ----------------------------------------------------------------------------
// mtg_pkg: shared types, constants and functions
// Request codes, queue entry type and the MT19937 word arithmetic used by
// the front and back of the generator.
// ----------------------------------------------------------------------------
package mtg_pkg;

    localparam int STATE_DEPTH  = 624;
    localparam int TWIST_OFFSET = 397;
    localparam int ADDR_W       = $clog2(STATE_DEPTH + 2);
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef logic [ADDR_W-1:0] t_addr;

    localparam t_addr ADDR_DEPTH = t_addr'(STATE_DEPTH);
    localparam t_addr ADDR_LAST  = t_addr'(STATE_DEPTH - 1);
    localparam t_addr ADDR_NEVER = t_addr'(STATE_DEPTH + 1);
    localparam t_addr ADDR_OFS   = t_addr'(TWIST_OFFSET);
    localparam t_addr ADDR_WRAP  = t_addr'(STATE_DEPTH - TWIST_OFFSET);

    localparam logic [31:0] DEFAULT_SEED = 32'd4357;
    localparam logic [31:0] LCG_MULT     = 32'd69069;
    localparam logic [31:0] TWIST_XOR    = 32'h9908b0df;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc60000;

    // request codes on the input channel
    localparam logic [1:0] REQ_DRAW = 2'd0;
    localparam logic [1:0] REQ_SEED = 2'd1;
    localparam logic [1:0] REQ_LOAD = 2'd2;

    typedef enum logic [1:0] {
        OP_DRAW = 2'd0,
        OP_SEED = 2'd1,
        OP_LOAD = 2'd2
    } t_op;

    typedef struct packed {
        t_op         op;
        t_addr       idx;
        logic [31:0] value;
    } t_cmd;

    function automatic logic [31:0] lcg_next(logic [31:0] s);
        return s * LCG_MULT + 32'd1;
    endfunction

    function automatic logic [31:0] twist_word(logic [31:0] cur, logic [31:0] nxt,
                                               logic [31:0] far);
        logic [31:0] y;
        logic [31:0] r;
        y = {cur[31], nxt[30:0]};
        r = far ^ (y >> 1);
        if (y[0]) begin
            r = r ^ TWIST_XOR;
        end
        return r;
    endfunction

    function automatic logic [31:0] temper(logic [31:0] x);
        logic [31:0] y;
        y = x;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

@@ rtl/mtg_front.sv @@
// ----------------------------------------------------------------------------
// mtg_front: request intake and command queue
// Accepts request transactions, drops unused codes and out-of-range loads,
// and queues the rest for the back end.
// ----------------------------------------------------------------------------
module mtg_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_req_type,
    input  logic [9:0]           i_word_index,
    input  logic [31:0]          i_word_value,
    output logic                 o_cmd_valid,
    output mtg_pkg::t_cmd        o_cmd,
    input  logic                 i_cmd_pop
);

    mtg_pkg::t_cmd                  r_q [mtg_pkg::QUEUE_DEPTH];
    logic [mtg_pkg::QPTR_W-1:0]     r_wp, n_wp;
    logic [mtg_pkg::QPTR_W-1:0]     r_rp, n_rp;
    logic [mtg_pkg::QCNT_W-1:0]     r_count, n_count;

    logic                           accept;
    logic                           keep;
    logic                           push;
    mtg_pkg::t_cmd                  cmd_in;

    assign o_in_stall  = (r_count == mtg_pkg::QCNT_W'(mtg_pkg::QUEUE_DEPTH));
    assign accept      = i_in_valid && !o_in_stall;
    assign push        = accept && keep;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        cmd_in.idx   = mtg_pkg::t_addr'(i_word_index);
        cmd_in.value = i_word_value;
        cmd_in.op    = mtg_pkg::OP_DRAW;
        keep         = 1'b0;
        unique case (i_req_type)
            mtg_pkg::REQ_DRAW: begin
                cmd_in.op = mtg_pkg::OP_DRAW;
                keep      = 1'b1;
            end
            mtg_pkg::REQ_SEED: begin
                cmd_in.op = mtg_pkg::OP_SEED;
                keep      = 1'b1;
            end
            mtg_pkg::REQ_LOAD: begin
                cmd_in.op = mtg_pkg::OP_LOAD;
                keep      = (i_word_index < mtg_pkg::ADDR_DEPTH);
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_wp    = push ? r_wp + 1'b1 : r_wp;
        n_rp    = i_cmd_pop ? r_rp + 1'b1 : r_rp;
        n_count = r_count + mtg_pkg::QCNT_W'(push) - mtg_pkg::QCNT_W'(i_cmd_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> (r_count != '0))
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mtg_pkg::QCNT_W'(mtg_pkg::QUEUE_DEPTH))
        else $error("queue count overflow");

endmodule

@@ rtl/mtg_back.sv @@
// ----------------------------------------------------------------------------
// mtg_back: state store sequencer
// Holds the 624-word state memory and runs seeding, twisting, loads and
// draws; tempered words leave through an output register.
// ----------------------------------------------------------------------------
module mtg_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [31:0]          i_seed,
    input  logic                 i_cmd_valid,
    input  mtg_pkg::t_cmd        i_cmd,
    output logic                 o_cmd_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [31:0]          o_random_word
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_FILL_HI  = 7'b0000010,
        S_FILL_LO  = 7'b0000100,
        S_TW_PRE   = 7'b0001000,
        S_TW_RUN   = 7'b0010000,
        S_DRAW_RD  = 7'b0100000,
        S_DRAW_OUT = 7'b1000000
    } t_state;

    logic [31:0]        r_mem [mtg_pkg::STATE_DEPTH];

    t_state             r_state, n_state;
    mtg_pkg::t_addr     r_pos, n_pos;
    mtg_pkg::t_addr     r_cnt, n_cnt;
    logic               r_wpend, n_wpend;
    logic               r_draw_after, n_draw_after;
    logic               r_out_valid, n_out_valid;
    logic [31:0]        r_out_word, n_out_word;
    logic [31:0]        r_s, n_s;
    logic [15:0]        r_hi, n_hi;
    logic [31:0]        r_cur, n_cur;
    logic [31:0]        r_rd_a;
    logic [31:0]        r_rd_b;

    logic               w_en;
    mtg_pkg::t_addr     w_addr;
    logic [31:0]        w_data;
    logic               ra_en;
    mtg_pkg::t_addr     ra_addr;
    logic               rb_en;
    mtg_pkg::t_addr     rb_addr;

    assign o_out_valid   = r_out_valid;
    assign o_random_word = r_out_word;

    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        n_cnt        = r_cnt;
        n_wpend      = r_wpend;
        n_draw_after = r_draw_after;
        n_out_valid  = r_out_valid;
        n_out_word   = r_out_word;
        n_s          = r_s;
        n_hi         = r_hi;
        n_cur        = r_cur;
        o_cmd_pop    = 1'b0;
        w_en         = 1'b0;
        w_addr       = r_cnt;
        w_data       = '0;
        ra_en        = 1'b0;
        ra_addr      = '0;
        rb_en        = 1'b0;
        rb_addr      = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.op)
                        mtg_pkg::OP_LOAD: begin
                            w_en   = 1'b1;
                            w_addr = i_cmd.idx;
                            w_data = i_cmd.value;
                            n_pos  = mtg_pkg::ADDR_DEPTH;
                        end
                        mtg_pkg::OP_SEED: begin
                            n_s          = i_seed;
                            n_cnt        = '0;
                            n_draw_after = 1'b0;
                            n_state      = S_FILL_HI;
                        end
                        mtg_pkg::OP_DRAW: begin
                            if (r_pos == mtg_pkg::ADDR_NEVER) begin
                                n_s          = mtg_pkg::DEFAULT_SEED;
                                n_cnt        = '0;
                                n_draw_after = 1'b1;
                                n_state      = S_FILL_HI;
                            end else if (r_pos == mtg_pkg::ADDR_DEPTH) begin
                                n_state = S_TW_PRE;
                            end else begin
                                n_state = S_DRAW_RD;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_FILL_HI: begin
                n_hi    = r_s[31:16];
                n_s     = mtg_pkg::lcg_next(r_s);
                n_state = S_FILL_LO;
            end
            S_FILL_LO: begin
                w_en   = 1'b1;
                w_addr = r_cnt;
                w_data = {r_hi, r_s[31:16]};
                n_s    = mtg_pkg::lcg_next(r_s);
                if (r_cnt == mtg_pkg::ADDR_LAST) begin
                    n_pos   = mtg_pkg::ADDR_DEPTH;
                    n_state = r_draw_after ? S_TW_PRE : S_IDLE;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_FILL_HI;
                end
            end
            S_TW_PRE: begin
                // prime word 0 so the first step has its own old value
                ra_en   = 1'b1;
                ra_addr = '0;
                n_cnt   = '0;
                n_wpend = 1'b0;
                n_state = S_TW_RUN;
            end
            S_TW_RUN: begin
                // write step k-1 while reading next and far words of step k
                n_cur = r_rd_a;
                if (r_wpend) begin
                    w_en   = 1'b1;
                    w_addr = r_cnt - 1'b1;
                    w_data = mtg_pkg::twist_word(r_cur, r_rd_a, r_rd_b);
                end
                if (r_cnt != mtg_pkg::ADDR_DEPTH) begin
                    ra_en   = 1'b1;
                    ra_addr = (r_cnt == mtg_pkg::ADDR_LAST) ? '0 : r_cnt + 1'b1;
                    rb_en   = 1'b1;
                    rb_addr = (r_cnt < mtg_pkg::ADDR_WRAP) ? r_cnt + mtg_pkg::ADDR_OFS
                                                           : r_cnt - mtg_pkg::ADDR_WRAP;
                    n_cnt   = r_cnt + 1'b1;
                    n_wpend = 1'b1;
                end else begin
                    n_wpend = 1'b0;
                    n_pos   = '0;
                    n_state = S_DRAW_RD;
                end
            end
            S_DRAW_RD: begin
                ra_en   = 1'b1;
                ra_addr = r_pos;
                n_state = S_DRAW_OUT;
            end
            S_DRAW_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_word  = mtg_pkg::temper(r_rd_a);
                    n_pos       = r_pos + 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pos        <= mtg_pkg::ADDR_NEVER;
            r_cnt        <= '0;
            r_wpend      <= 1'b0;
            r_draw_after <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pos        <= n_pos;
            r_cnt        <= n_cnt;
            r_wpend      <= n_wpend;
            r_draw_after <= n_draw_after;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
        r_s        <= n_s;
        r_hi       <= n_hi;
        r_cur      <= n_cur;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ra_en) begin
            r_rd_a <= r_mem[ra_addr];
        end
        if (rb_en) begin
            r_rd_b <= r_mem[rb_addr];
        end
    end

    a_out_from_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DRAW_OUT))
        else $error("output loaded outside a draw");

    a_twist_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state == S_TW_RUN) && r_state == S_DRAW_RD) |-> (r_pos == '0))
        else $error("read position not cleared after twist");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAW_RD) |-> (r_pos < mtg_pkg::ADDR_DEPTH))
        else $error("draw read beyond the store");

endmodule

@@ rtl/mersenne_twister_generator.sv @@
// ----------------------------------------------------------------------------
// mersenne_twister_generator: MT19937 word generator
// Front queue classifies requests; back end runs the 624-word state store.
//
//   channel   direction  handshake                    payload
//   request   in         i_in_valid / o_in_stall      i_req_type, i_word_index,
//                                                     i_word_value
//   result    out        o_out_valid / i_out_stall    o_random_word
//   seed cfg  in         i_cfg_valid / o_cfg_ready    i_cfg_data
//
// Draw without twist: popped in S_IDLE, read in S_DRAW_RD and tempered into
// the output register in S_DRAW_OUT. Twist: one word per cycle on the
// two-read-port state memory. Seeding: two LCG multiplies per state word.
// Load: written in S_IDLE as it is popped. Reset is synchronous; the state
// store is not cleared. A stalled result holds the back end in the draw;
// the 4-entry queue keeps accepting requests until full.
// ----------------------------------------------------------------------------
module mersenne_twister_generator (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  logic [1:0]   i_req_type,
    input  logic [9:0]   i_word_index,
    input  logic [31:0]  i_word_value,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output logic [31:0]  o_random_word,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [31:0]  i_cfg_data
);

    logic [31:0]        r_seed;
    logic               cmd_valid;
    logic               cmd_pop;
    mtg_pkg::t_cmd      cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= mtg_pkg::DEFAULT_SEED;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_seed <= i_cfg_data;
        end
    end

    mtg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_word_index (i_word_index),
        .i_word_value (i_word_value),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_cmd_pop    (cmd_pop)
    );

    mtg_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_seed        (r_seed),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd),
        .o_cmd_pop     (cmd_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_random_word (o_random_word)
    );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: MT19937 word generator
// Directed table, then three random phases (mixed requests, a long draw run
// across the store wrap, mixed again). A local model of the store predicts
// every drawn word; results are checked in order as they leave the block.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [1:0] REQ_SPARE   = 2'd3;  // unused code, ignored by the block
    localparam int         NEVER_POS   = mtg_pkg::STATE_DEPTH + 1;
    localparam int         IDLE_CYCLES = 8000;  // covers a full queue of reseeds
    localparam int         HOLD_CYCLES = 300;
    localparam int         LIMIT       = 1000000;
    localparam int         N_DIR       = 24;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct packed {
        logic [1:0]  req;
        logic [9:0]  idx;
        logic [31:0] val;
    } t_item;

    typedef struct packed {
        t_row_kind   kind;
        logic [1:0]  req;
        logic [9:0]  idx;
        logic [31:0] val;
        int          n_res;
    } t_row;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_req_type   = '0;
    logic [9:0]  i_word_index = '0;
    logic [31:0] i_word_value = '0;
    logic        o_out_valid;
    logic        i_out_stall  = 1'b0;
    logic [31:0] o_random_word;
    logic        i_cfg_valid  = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data   = '0;

    mersenne_twister_generator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_word_index  (i_word_index),
        .i_word_value  (i_word_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_random_word (o_random_word),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // local model of the generator
    // ------------------------------------------------------------------
    logic [31:0] mt_words [mtg_pkg::STATE_DEPTH];
    int          mt_pos   = NEVER_POS;
    logic [31:0] seed_reg = mtg_pkg::DEFAULT_SEED;

    logic [31:0] words_due [$];
    int          errors      = 0;
    int          cycle_count = 0;
    int          burst_left  = 0;
    int          rush_left   = 0;
    int          hold_ask    = 0;
    int          hold_seen   = 0;
    int          hold_left   = 0;
    int          mode        = 0;
    int          mode_left   = 0;

    function automatic void mt_fill(input logic [31:0] s);
        logic [31:0] lcg;
        logic [15:0] hi;
        lcg = s;
        for (int k = 0; k < mtg_pkg::STATE_DEPTH; k++) begin
            hi = lcg[31:16];
            lcg = lcg * mtg_pkg::LCG_MULT + 32'd1;
            mt_words[k] = {hi, lcg[31:16]};
            lcg = lcg * mtg_pkg::LCG_MULT + 32'd1;
        end
        mt_pos = mtg_pkg::STATE_DEPTH;
    endfunction

    function automatic void mt_twist();
        logic [31:0] y;
        logic [31:0] nxt;
        logic [31:0] far;
        // in place: late words see already twisted neighbors, as in the scheme
        for (int k = 0; k < mtg_pkg::STATE_DEPTH; k++) begin
            nxt = mt_words[(k + 1) % mtg_pkg::STATE_DEPTH];
            far = mt_words[(k + mtg_pkg::TWIST_OFFSET) % mtg_pkg::STATE_DEPTH];
            y = {mt_words[k][31], nxt[30:0]};
            mt_words[k] = far ^ (y >> 1) ^ (y[0] ? mtg_pkg::TWIST_XOR : 32'h0);
        end
        mt_pos = 0;
    endfunction

    function automatic logic [31:0] mt_tempered(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & mtg_pkg::TEMPER_B);
        y = y ^ ((y << 15) & mtg_pkg::TEMPER_C);
        return y ^ (y >> 18);
    endfunction

    // returns 1 when the request yields a word
    function automatic bit mt_advance(input t_item it, output logic [31:0] word);
        word = '0;
        case (it.req)
            mtg_pkg::REQ_DRAW: begin
                if (mt_pos >= mtg_pkg::STATE_DEPTH) begin
                    if (mt_pos == NEVER_POS) begin
                        mt_fill(mtg_pkg::DEFAULT_SEED);
                    end
                    mt_twist();
                end
                word = mt_tempered(mt_words[mt_pos]);
                mt_pos++;
                return 1'b1;
            end
            mtg_pkg::REQ_SEED: begin
                mt_fill(seed_reg);
            end
            mtg_pkg::REQ_LOAD: begin
                if (it.idx < mtg_pkg::STATE_DEPTH) begin
                    mt_words[it.idx] = it.val;
                    mt_pos = mtg_pkg::STATE_DEPTH;
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // random request mixes
    // ------------------------------------------------------------------
    function automatic t_item rand_mixed();
        t_item       it;
        int unsigned p;
        it.idx = 10'($urandom_range(0, 1023));
        it.val = $urandom();
        p = $urandom_range(0, 99);
        if (p < 80) begin
            it.req = mtg_pkg::REQ_DRAW;
        end else if (p < 83) begin
            it.req = mtg_pkg::REQ_SEED;
        end else if (p < 93) begin
            it.req = mtg_pkg::REQ_LOAD;
            it.idx = 10'($urandom_range(0, mtg_pkg::STATE_DEPTH - 1));
        end else if (p < 97) begin
            it.req = mtg_pkg::REQ_LOAD;
            it.idx = 10'($urandom_range(mtg_pkg::STATE_DEPTH, 1023));
        end else begin
            it.req = REQ_SPARE;
        end
        return it;
    endfunction

    // draws only, with noise the block must ignore
    function automatic t_item rand_draw_run();
        t_item       it;
        int unsigned p;
        it.idx = 10'($urandom_range(0, 1023));
        it.val = $urandom();
        p = $urandom_range(0, 99);
        if (p < 95) begin
            it.req = mtg_pkg::REQ_DRAW;
        end else if (p < 97) begin
            it.req = REQ_SPARE;
        end else begin
            it.req = mtg_pkg::REQ_LOAD;
            it.idx = 10'($urandom_range(mtg_pkg::STATE_DEPTH, 1023));
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // request channel driver, called at a rising edge
    // ------------------------------------------------------------------
    task automatic offer_request(input t_item it, output bit made, output logic [31:0] word);
        bit stalled;
        int gap;
        if (rush_left > 0) begin
            rush_left--;
        end else if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= it.req;
        i_word_index <= it.idx;
        i_word_value <= it.val;
        do begin
            @(negedge i_clk);
            stalled = o_in_stall;
            @(posedge i_clk);
        end while (stalled);
        made = mt_advance(it, word);
    endtask

    task automatic send_random(input t_item it);
        bit          made;
        logic [31:0] word;
        offer_request(it, made, word);
        if (made) begin
            words_due.push_back(word);
        end
    endtask

    // lower valid, let every expected word come out, then let the back end settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (words_due.size() != 0) @(posedge i_clk);
        repeat (IDLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [31:0] v);
        bit rdy;
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do begin
            @(negedge i_clk);
            rdy = o_cfg_ready;
            @(posedge i_clk);
        end while (!rdy);
        i_cfg_valid <= 1'b0;
        seed_reg = v;
    endtask

    task automatic flag_error(input bit unexpected, input logic [31:0] exp_w,
                              input logic [31:0] act_w);
        errors++;
        if (errors <= 10) begin
            if (unexpected) begin
                $display("unexpected transaction: random_word %08h", act_w);
            end else begin
                $display("mismatch: random_word expected %08h got %08h", exp_w, act_w);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // result monitor: sampled mid-cycle, accepted at the next rising edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        logic [31:0] exp_w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (words_due.size() == 0) begin
                flag_error(1'b1, '0, o_random_word);
            end else begin
                exp_w = words_due.pop_front();
                if (exp_w !== o_random_word) begin
                    flag_error(1'b0, exp_w, o_random_word);
                end
            end
        end
    end

    // receiver back-pressure: changing modes, plus a long hold on request
    always @(posedge i_clk) begin
        if (hold_seen != hold_ask) begin
            hold_seen   <= hold_ask;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                mode      <= $urandom_range(0, 3);
                mode_left <= $urandom_range(16, 128);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 3) != 0);
                default: i_out_stall <= ~i_out_stall;
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    t_row dir_rows [N_DIR];

    initial begin
        bit          made;
        logic [31:0] word;
        t_item       it;

        dir_rows = '{
            '{ROW_REQ, mtg_pkg::REQ_DRAW, 10'd0,    32'h0000_0000, 1},  // first draw seeds
            '{ROW_REQ, mtg_pkg::REQ_DRAW, 10'd1023, 32'hffff_ffff, 1},
            '{ROW_REQ, REQ_SPARE,         10'd0,    32'h0000_0000, 0},
            '{ROW_REQ, REQ_SPARE,         10'd1023, 32'hffff_ffff, 0},
            '{ROW_REQ, mtg_pkg::REQ_LOAD, 10'd624,  32'h1234_5678, 0},  // past the store
            '{ROW_REQ, mtg_pkg::REQ_LOAD, 10'd1023, 32'hffff_ffff, 0},
            '{ROW_REQ, mtg_pkg::REQ_DRAW, 10'd0,    32'h0000_0000, 1},
            '{ROW_REQ, mtg_pkg::REQ_LOAD, 10'd0,    32'h0000_0000, 0},
            '{ROW_REQ, mtg_pkg::REQ_LOAD, 10'd623,  32'hffff_ffff, 0},
            '{ROW_REQ, mtg_pkg::REQ_LOAD, 10'd341,  32'h5555_5555, 0},
            '{ROW_REQ, mtg_pkg::REQ_LOAD, 10'd682,  32'haaaa_aaaa, 0},
            '{ROW_REQ, mtg_pkg::REQ_DRAW, 10'd0,    32'h0000_0000, 1},  // twist after loads
            '{ROW_REQ, mtg_pkg::REQ_DRAW, 10'd0,    32'h0000_0000, 1},
            '{ROW_REQ, mtg_pkg::REQ_SEED, 10'd0,    32'h0000_0000, 0},  // reset seed value
            '{ROW_REQ, mtg_pkg::REQ_DRAW, 10'd0,    32'h0000_0000, 1},
            '{ROW_CFG, mtg_pkg::REQ_DRAW, 10'd0,    32'h0000_0000, 0},
            '{ROW_REQ, mtg_pkg::REQ_SEED, 10'd1023, 32'hffff_ffff, 0},
            '{ROW_REQ, mtg_pkg::REQ_DRAW, 10'd0,    32'h0000_0000, 1},
            '{ROW_REQ, mtg_pkg::REQ_DRAW, 10'd0,    32'h0000_0000, 1},
            '{ROW_CFG, mtg_pkg::REQ_DRAW, 10'd0,    32'hffff_ffff, 0},
            '{ROW_REQ, mtg_pkg::REQ_SEED, 10'd0,    32'h0000_0000, 0},
            '{ROW_REQ, mtg_pkg::REQ_DRAW, 10'd0,    32'h0000_0000, 1},
            '{ROW_REQ, mtg_pkg::REQ_LOAD, 10'd5,    32'h8000_0000, 0},
            '{ROW_REQ, mtg_pkg::REQ_DRAW, 10'd0,    32'h0000_0000, 1}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_DIR; r++) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                write_seed(dir_rows[r].val);
            end else begin
                it = '{dir_rows[r].req, dir_rows[r].idx, dir_rows[r].val};
                offer_request(it, made, word);
                if (dir_rows[r].n_res == 1) begin
                    words_due.push_back(word);
                end
            end
        end

        write_seed($urandom());
        repeat (500) send_random(rand_mixed());

        // long draw run from a fresh seed, crossing the end of the store
        write_seed($urandom());
        send_random('{mtg_pkg::REQ_SEED, 10'd0, 32'h0});
        for (int n = 0; n < 700; n++) begin
            if (n == 100) begin
                hold_ask  <= hold_ask + 1;
                rush_left = 40;
            end
            send_random(rand_draw_run());
        end

        write_seed($urandom());
        repeat (500) send_random(rand_mixed());

        wait_idle();
        if (errors == 0 && words_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
